// File: rtl/core/udiv_pkg.sv
// Package for the 256-bit unsigned divider core.
// Holds the transaction payload types, the controller/datapath command and status
// structs, and the width constants. No dependencies.
package udiv_pkg;

  localparam int LIMB_W     = 64;
  localparam int WORD_W     = 32;
  localparam int MAX_WORDS  = 8;
  localparam int FULL_W     = WORD_W * MAX_WORDS;
  localparam int WORDS_DEF  = 8;

  typedef struct packed {
    logic [LIMB_W-1:0] divisor_w3;
    logic [LIMB_W-1:0] divisor_w2;
    logic [LIMB_W-1:0] divisor_w1;
    logic [LIMB_W-1:0] divisor_w0;
    logic [LIMB_W-1:0] dividend_w3;
    logic [LIMB_W-1:0] dividend_w2;
    logic [LIMB_W-1:0] dividend_w1;
    logic [LIMB_W-1:0] dividend_w0;
  } udiv_in_t;

  typedef struct packed {
    logic [LIMB_W-1:0] quotient_w3;
    logic [LIMB_W-1:0] quotient_w2;
    logic [LIMB_W-1:0] quotient_w1;
    logic [LIMB_W-1:0] quotient_w0;
  } udiv_out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } udiv_cmd_t;

  typedef struct packed {
    logic last;
  } udiv_stat_t;

endpackage

// File: rtl/core/udiv_dp.sv
// Datapath of the divider: operand, remainder and quotient registers, one
// restoring shift-and-subtract step per cycle, step counter and result register.
// Depends on udiv_pkg.
module udiv_dp import udiv_pkg::*; #(
  parameter int NumWords = WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  udiv_cmd_t  cmd_i,
  output udiv_stat_t stat_o,
  input  udiv_in_t   in_data_i,
  output udiv_out_t  out_data_o
);

  localparam int NW   = (NumWords < 1) ? 1 : ((NumWords > MAX_WORDS) ? MAX_WORDS : NumWords);
  localparam int W    = WORD_W * NW;
  localparam int CntW = $clog2(W);

  logic [FULL_W-1:0] num_full, den_full, quo_full;
  logic [W-1:0]      rem_q, rem_d, quo_q, quo_d, den_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              zero_q;
  logic [W:0]        r2;
  logic [W+1:0]      diff;
  logic              fits;
  udiv_out_t         res_q;

  assign num_full = {in_data_i.dividend_w3, in_data_i.dividend_w2,
                     in_data_i.dividend_w1, in_data_i.dividend_w0};
  assign den_full = {in_data_i.divisor_w3, in_data_i.divisor_w2,
                     in_data_i.divisor_w1, in_data_i.divisor_w0};

  assign r2   = {rem_q, quo_q[W-1]};
  assign diff = {1'b0, r2} - {2'b00, den_q};
  assign fits = ~diff[W+1];

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      rem_d = '0;
      quo_d = num_full[W-1:0];
      cnt_d = CntW'(W - 1);
    end else if (cmd_i.step) begin
      rem_d = fits ? diff[W-1:0] : r2[W-1:0];
      quo_d = {quo_q[W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_comb begin
    quo_full = '0;
    if (!zero_q) begin
      quo_full[W-1:0] = quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.load) begin
      den_q  <= den_full[W-1:0];
      zero_q <= ~|den_full[W-1:0];
    end
    if (cmd_i.publish) begin
      res_q <= udiv_out_t'(quo_full);
    end
  end

  assign stat_o.last = (cnt_q == '0);
  assign out_data_o  = res_q;

endmodule

// File: rtl/core/udiv_ctrl.sv
// Controller of the divider: sequences load, step and publish, and owns the
// input stall and the output valid register. Depends on udiv_pkg.
module udiv_ctrl import udiv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output udiv_cmd_t  cmd_o,
  input  udiv_stat_t stat_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o.load    = 1'b0;
    cmd_o.step    = 1'b0;
    cmd_o.publish = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        cmd_o.step = 1'b1;
        if (stat_i.last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (slot_free) begin
          cmd_o.publish = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.publish}))
    else $error("more than one datapath command at once");

  a_run_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) && !stat_i.last |=> (state_q == StRun))
    else $error("left run before the last step");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) && stat_i.last |=> (state_q == StDone))
    else $error("missed the end of the division");

  a_publish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> out_valid_q)
    else $error("published result not shown as valid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

endmodule

// File: rtl/core/uint256_divider_core.sv
// Top level of the 256-bit unsigned divider: controller plus datapath.
// Depends on udiv_pkg, udiv_ctrl and udiv_dp.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries a dividend and a
//   divisor as four 64-bit limbs each. Output channel out_valid_o / out_stall_i /
//   out_data_o carries the floor quotient as four 64-bit limbs.
//   A transaction moves at a rising edge where valid is high and stall is low.
//   Only the low 32*NumWords bits of each operand are used; the quotient bits
//   above that read as zero. A zero divisor gives a zero quotient.
// Timing:
//   One quotient bit per cycle through a single (32*NumWords+1)-bit subtractor;
//   after the last step the quotient is published to the output register, and
//   a new input is taken only after that publish, once the controller is idle.
//   The result sits in an output register, so the next division starts while
//   it waits; a stalled receiver holds the finished second result in the
//   datapath and keeps in_stall_o high until the output register frees.
// Reset:
//   rst_ni clears the controller and output valid; no division is in flight.
module uint256_divider_core import udiv_pkg::*; #(
  parameter int NumWords = WORDS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  udiv_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output udiv_out_t out_data_o
);

  udiv_cmd_t  cmd;
  udiv_stat_t stat;

  udiv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  udiv_dp #(
    .NumWords (NumWords)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
